[src/spcr_pkg.sv]
// Shared types and constants for the SPI control packet receiver.
// No dependencies; imported by every module of the block.
package spcr_pkg;

  // Packet geometry
  localparam int PACKET_BYTES = 18;
  localparam int IDX_W        = $clog2(PACKET_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PACKET_BYTES - 1);

  // Byte 0 is the magic, bytes 1..NUM_CH carry the control channels
  localparam int NUM_CH      = 6;
  localparam int STORE_BYTES = NUM_CH + 1;
  localparam int CH_SEL_W    = $clog2(NUM_CH);
  localparam int CH_W        = 11;

  // Channel mapping: 1000 + floor(x*1000/255) = 1000 + floor(x*200/51)
  // floor(y/51) done as (y * ceil(2^21/51)) >> 21, exact for y <= 51000
  localparam logic [15:0]     MAP_RECIP = 16'd41121;
  localparam int              MAP_SHIFT = 21;
  localparam logic [CH_W-1:0] MAP_BASE  = 11'd1000;

  // Config register indices (word address paddr[3:2])
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = 4;
  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_CODE   = 2'd0,
    REG_PACKET_MAGIC = 2'd1,
    REG_ACCEPT_CODE  = 2'd2,
    REG_REJECT_CODE  = 2'd3
  } reg_idx_e;

  // Reset values
  localparam logic [7:0] START_CODE_RST   = 8'd251;
  localparam logic [7:0] PACKET_MAGIC_RST = 8'd110;
  localparam logic [7:0] ACCEPT_CODE_RST  = 8'd252;
  localparam logic [7:0] REJECT_CODE_RST  = 8'd145;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] packet_magic;
    logic [7:0] accept_code;
    logic [7:0] reject_code;
  } cfg_t;

  typedef struct packed {
    logic       reply_write;
    logic [7:0] reply_byte;
    logic       packet_done;
    logic       packet_good;
  } res_t;

  typedef logic [NUM_CH-1:0][CH_W-1:0] chan_arr_t;

endpackage

[src/spcr_cfg_regs.sv]
// APB-style configuration registers for the packet receiver.
// Depends on spcr_pkg (register indices, reset values, cfg_t).
module spcr_cfg_regs import spcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_START_CODE:   cfg_d.start_code   = pwdata[7:0];
        REG_PACKET_MAGIC: cfg_d.packet_magic = pwdata[7:0];
        REG_ACCEPT_CODE:  cfg_d.accept_code  = pwdata[7:0];
        REG_REJECT_CODE:  cfg_d.reject_code  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START_CODE:   prdata = 32'(cfg_q.start_code);
      REG_PACKET_MAGIC: prdata = 32'(cfg_q.packet_magic);
      REG_ACCEPT_CODE:  prdata = 32'(cfg_q.accept_code);
      REG_REJECT_CODE:  prdata = 32'(cfg_q.reject_code);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code   <= START_CODE_RST;
      cfg_q.packet_magic <= PACKET_MAGIC_RST;
      cfg_q.accept_code  <= ACCEPT_CODE_RST;
      cfg_q.reject_code  <= REJECT_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/spcr_chan_map.sv]
// Maps a raw control byte onto the 1000..2000 channel range.
// Depends on spcr_pkg (reciprocal constant and widths).
module spcr_chan_map import spcr_pkg::*; (
  input  logic [7:0]      byte_i,
  output logic [CH_W-1:0] chan_o
);

  logic [15:0] scaled;   // x*200, at most 51000
  logic [31:0] prod;
  logic [9:0]  quot;     // at most 1000

  assign scaled = {1'b0, byte_i, 7'b0} + {2'b0, byte_i, 6'b0} + {5'b0, byte_i, 3'b0};
  assign prod   = 32'(scaled) * 32'(MAP_RECIP);
  assign quot   = prod[MAP_SHIFT+9:MAP_SHIFT];
  assign chan_o = CH_W'(quot) + MAP_BASE;

endmodule

[src/spcr_parser.sv]
// Packet parser: idle/armed sequencer, byte store and held channel values.
// Depends on spcr_pkg and spcr_chan_map.
module spcr_parser import spcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o,
  output chan_arr_t  chan_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_ARMED = 1'b1;

  logic             state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       magic_q;
  chan_arr_t        pend_q;   // mapped values of the current packet
  chan_arr_t        chan_q;   // held values of the last good packet
  logic [CH_W-1:0]  mapped;
  logic             chan_we;
  logic             store_we;
  logic [CH_SEL_W-1:0] ch_sel;

  spcr_chan_map u_map (
    .byte_i (byte_i),
    .chan_o (mapped)
  );

  assign ch_sel = CH_SEL_W'(idx_q - IDX_W'(1));

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    res_o    = '0;
    chan_we  = 1'b0;
    store_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (step_i && byte_i == cfg_i.start_code) begin
          state_d = ST_ARMED;
          idx_d   = '0;
        end
      end
      ST_ARMED: begin
        if (step_i) begin
          res_o.reply_write = 1'b1;
          if (idx_q != LAST_IDX) begin
            res_o.reply_byte = 8'(idx_q) + 8'd1;
            idx_d            = idx_q + IDX_W'(1);
            store_we         = 1'b1;
          end else begin
            state_d           = ST_IDLE;
            res_o.packet_done = 1'b1;
            res_o.packet_good = (magic_q == cfg_i.packet_magic);
            res_o.reply_byte  = res_o.packet_good ? cfg_i.accept_code : cfg_i.reject_code;
            chan_we           = res_o.packet_good;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      chan_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (chan_we) begin
        chan_q <= pend_q;
      end
    end
  end

  // Only the magic and channel bytes are kept; the rest are never read
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      if (idx_q == '0) begin
        magic_q <= byte_i;
      end else if (idx_q < IDX_W'(STORE_BYTES)) begin
        pend_q[ch_sel] <= mapped;
      end
    end
  end

  assign chan_o = chan_q;

endmodule

[src/spi_control_packet_receiver_core.sv]
// Top level of the SPI control packet receiver: handshake pipeline around
// the parser. Depends on spcr_pkg, spcr_cfg_regs and spcr_parser.
//
//   port group        direction  purpose
//   in_*  / rx_byte   in         one received SPI byte per word
//   out_* / results   out        reply, packet status, held channels
//   APB (p*)          in/out     four 8-bit config registers at 0x0..0xC
//
// One word per cycle sustained while out_stall_i is low. A word is held in
// the input register and is parsed on its way into the result register,
// which drives the outputs until the word is taken.
// The result register frees as soon as its word is taken; in_stall_o rises
// only when both registers are full and out_stall_i is high.
// Reset clears the sequencer to idle, the held channels to zero and the
// config registers to their defaults; no clearing pass is needed.
module spi_control_packet_receiver_core import spcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               reply_write_o,
  output logic [7:0]         reply_byte_o,
  output logic               packet_done_o,
  output logic               packet_good_o,
  output logic [CH_W-1:0]    throttle_out_o,
  output logic [CH_W-1:0]    yaw_out_o,
  output logic [CH_W-1:0]    pitch_out_o,
  output logic [CH_W-1:0]    roll_out_o,
  output logic [CH_W-1:0]    aux_one_out_o,
  output logic [CH_W-1:0]    aux_two_out_o,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg;
  res_t       res;
  chan_arr_t  chan;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       out_vld_q, out_vld_d;
  res_t       out_res_q;
  logic       out_free;   // result register can load this cycle
  logic       proc;       // word in the input register is parsed now
  logic       in_take;

  spcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spcr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (proc),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res),
    .chan_o (chan)
  );

  assign out_free   = ~out_vld_q | ~out_stall_i;
  assign proc       = in_vld_q & out_free;
  assign in_stall_o = in_vld_q & ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_free ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (proc) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign reply_write_o = out_res_q.reply_write;
  assign reply_byte_o  = out_res_q.reply_byte;
  assign packet_done_o = out_res_q.packet_done;
  assign packet_good_o = out_res_q.packet_good;

  // Held channels only change when a word is parsed into the result
  // register, so they always match the word being shown. Byte order:
  // throttle, pitch, roll, yaw, aux one, aux two.
  assign throttle_out_o = chan[0];
  assign pitch_out_o    = chan[1];
  assign roll_out_o     = chan[2];
  assign yaw_out_o      = chan[3];
  assign aux_one_out_o  = chan[4];
  assign aux_two_out_o  = chan[5];

endmodule
